@@ rtl/i2cse_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cse_pkg
// Shared types, codes and the status classifier of the slave event handler.
// ----------------------------------------------------------------------------
package i2cse_pkg;

  // Item kinds on the request channel.
  localparam logic [1:0] KIND_BUS  = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Event classes reported with each result.
  localparam logic [3:0] EV_NONE   = 4'd0;
  localparam logic [3:0] EV_START  = 4'd1;
  localparam logic [3:0] EV_STOP   = 4'd2;
  localparam logic [3:0] EV_ADDR_W = 4'd3;
  localparam logic [3:0] EV_DATA_W = 4'd4;
  localparam logic [3:0] EV_ADDR_R = 4'd5;
  localparam logic [3:0] EV_DATA_R = 4'd6;
  localparam logic [3:0] EV_NACK   = 4'd7;
  localparam logic [3:0] EV_ERROR  = 4'd8;

  // Status byte masks and patterns.
  localparam logic [7:0] MASK_LOW    = 8'b0000_1111;
  localparam logic [7:0] PAT_START   = 8'b0000_1000;
  localparam logic [7:0] MASK_STOP   = 8'b0011_0000;
  localparam logic [7:0] MASK_EV     = 8'b0010_1101;
  localparam logic [7:0] PAT_ADDR_W  = 8'b0000_1001;
  localparam logic [7:0] PAT_DATA_W  = 8'b0010_1001;
  localparam logic [7:0] MASK_ADDR_R = 8'b1111_1110;
  localparam logic [7:0] PAT_ADDR_R  = 8'b0000_1100;
  localparam logic [7:0] MASK_DATA_R = 8'b1111_1011;
  localparam logic [7:0] PAT_DATA_R  = 8'b0010_1000;

  // One request item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] status_bits;
    logic       overflow;
    logic       clock_released;
    logic [7:0] bus_byte;
    logic [4:0] table_index;
    logic [7:0] table_data;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [3:0] event_class;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       message_ready;
    logic [5:0] message_length;
    logic       protocol_error;
    logic [7:0] read_data;
  } out_t;

  // Event part of a result, produced by the control unit.
  typedef struct packed {
    logic [3:0] event_class;
    logic       send_valid;
    logic       message_ready;
    logic [5:0] message_length;
    logic       protocol_error;
  } ev_res_t;

  // Classify a status byte, highest priority first.
  function automatic logic [3:0] classify(input logic [7:0] status, input logic released);
    logic [7:0] m;
    logic [3:0] cls;
    m = status & MASK_EV;
    if ((status & MASK_LOW) == PAT_START) begin
      cls = EV_START;
    end else if ((status & MASK_STOP) == MASK_STOP) begin
      cls = EV_STOP;
    end else if (m == PAT_ADDR_W) begin
      cls = EV_ADDR_W;
    end else if ((m | PAT_START) == PAT_DATA_W) begin
      cls = EV_DATA_W;
    end else if ((m & MASK_ADDR_R) == PAT_ADDR_R) begin
      cls = EV_ADDR_R;
    end else if ((m & MASK_DATA_R) == PAT_DATA_R) begin
      cls = released ? EV_NACK : EV_DATA_R;
    end else begin
      cls = EV_ERROR;
    end
    return cls;
  endfunction

endpackage

@@ rtl/i2cse_chan_if.sv @@
// ----------------------------------------------------------------------------
// i2cse_chan_if
// Valid/ready channel carrying one payload of a packed type.
// ----------------------------------------------------------------------------
interface i2cse_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

@@ rtl/i2cse_ram.sv @@
// ----------------------------------------------------------------------------
// i2cse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/i2cse_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2cse_ctrl
// Bus event control: classification, receive count, transmit pointer,
// message completion and the sticky protocol error.
// ----------------------------------------------------------------------------
module i2cse_ctrl #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  i2cse_pkg::in_t                  item,
  output i2cse_pkg::ev_res_t              res,
  output logic [$clog2(BUFFER_DEPTH)-1:0] tx_raddr,
  output logic                            rx_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rx_waddr
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          dp_r, dp_nxt;
  logic          err_r, err_nxt;

  logic [3:0]    cls;
  logic          is_bus;
  logic          finish;
  logic          room;

  // Classify the current item; a latched error masks every bus event.
  always_comb begin
    is_bus = (item.kind == i2cse_pkg::KIND_BUS);
    if (!is_bus) begin
      cls = i2cse_pkg::EV_NONE;
    end else if (err_r) begin
      cls = i2cse_pkg::EV_ERROR;
    end else begin
      cls = i2cse_pkg::classify(item.status_bits, item.clock_released);
    end
  end

  assign room   = (count_r < CW'(BUFFER_DEPTH));
  assign finish = dp_r && is_bus && !err_r &&
                  ((cls == i2cse_pkg::EV_STOP) || (cls == i2cse_pkg::EV_ADDR_W) ||
                   (cls == i2cse_pkg::EV_ADDR_R));

  // Next state of counters and flags.
  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    dp_nxt    = dp_r;
    err_nxt   = err_r;
    if (is_bus && !err_r) begin
      if (finish) begin
        count_nxt = '0;
        dp_nxt    = 1'b0;
      end
      case (cls)
        i2cse_pkg::EV_DATA_W: begin
          dp_nxt = 1'b1;
          if (room) begin
            count_nxt = count_r + CW'(1);
          end
        end
        i2cse_pkg::EV_ADDR_R: begin
          ptr_nxt = AW'(1);
        end
        i2cse_pkg::EV_DATA_R: begin
          if (ptr_r < AW'(BUFFER_DEPTH - 1)) begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
        i2cse_pkg::EV_ERROR: begin
          err_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields and buffer controls.
  always_comb begin
    res.event_class    = cls;
    res.send_valid     = (cls == i2cse_pkg::EV_ADDR_R) || (cls == i2cse_pkg::EV_DATA_R);
    res.message_ready  = finish;
    res.message_length = finish ? 6'(count_r) : 6'd0;
    res.protocol_error = err_nxt;
  end

  assign tx_raddr = (cls == i2cse_pkg::EV_ADDR_R) ? '0 : ptr_r;
  assign rx_we    = accept && (cls == i2cse_pkg::EV_DATA_W) && room;
  assign rx_waddr = count_r[AW-1:0];

  // State registers update only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      dp_r    <= 1'b0;
      err_r   <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      dp_r    <= dp_nxt;
      err_r   <= err_nxt;
    end
  end

  // The error latch is sticky until reset.
  assert property (@(posedge clk) disable iff (!rst_n) err_r |=> err_r)
    else $error("protocol error latch cleared without reset");

  // The receive count never passes the buffer depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(BUFFER_DEPTH))
    else $error("receive count beyond buffer depth");

  // Reporting a message clears the pending flag and the receive count.
  assert property (@(posedge clk) disable iff (!rst_n)
                   accept && res.message_ready |=> !dp_r && (count_r == '0))
    else $error("message completion left data pending");

endmodule

@@ rtl/i2c_slave_event_handler_core.sv @@
// ----------------------------------------------------------------------------
// i2c_slave_event_handler_core
// Serial-bus slave event handler with receive and transmit buffers.
// A result passes the stage-one register, held alongside the buffer read
// register, and then the output register.
// Throughput: one request per cycle while results are taken; the output
// register and the stage before it let a new request in while a result waits.
// Reset (synchronous, rst_n low) clears control state and the per-entry
// valid bits; entries never written read as zero, so no clearing pass runs.
// ----------------------------------------------------------------------------
module i2c_slave_event_handler_core #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  i2cse_chan_if.sink           in_chan,
  i2cse_chan_if.source         out_chan,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic REG_OWN_ADDR = 1'b0;

  i2cse_pkg::in_t     item;
  i2cse_pkg::ev_res_t ev_res;
  logic               accept;
  logic               in_range;
  logic [AW-1:0]      idx_addr;
  logic [AW-1:0]      tx_raddr;
  logic [AW-1:0]      rx_waddr;
  logic               rx_we;
  logic               tx_we;
  logic [7:0]         tx_q;
  logic [7:0]         rx_q;

  logic [BUFFER_DEPTH-1:0] tx_vld_r;
  logic [BUFFER_DEPTH-1:0] rx_vld_r;

  logic               s1_valid_r;
  i2cse_pkg::ev_res_t s1_res_r;
  logic               s1_tx_ok_r;
  logic               s1_rx_ok_r;
  logic               s1_move;

  logic               out_valid_r;
  i2cse_pkg::out_t    out_data_r;

  logic [6:0]         own_addr_r;

  // Configuration register: own address, read back on the same port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_OWN_ADDR)) begin
      own_addr_r <= pwdata[6:0];
    end
  end
  assign prdata = (paddr[2] == REG_OWN_ADDR) ? {25'd0, own_addr_r} : 32'd0;

  // Request handshake.
  assign item         = in_chan.payload;
  assign s1_move      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_move;
  assign accept       = in_chan.valid && in_chan.ready;

  assign in_range = (32'(item.table_index) < BUFFER_DEPTH);
  assign idx_addr = AW'(item.table_index);
  assign tx_we    = accept && (item.kind == i2cse_pkg::KIND_LOAD) && in_range;

  // Event control.
  i2cse_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (item),
    .res      (ev_res),
    .tx_raddr (tx_raddr),
    .rx_we    (rx_we),
    .rx_waddr (rx_waddr)
  );

  // Transmit buffer: host loads, bus reads.
  i2cse_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (idx_addr),
    .wdata (item.table_data),
    .re    (accept),
    .raddr (tx_raddr),
    .rdata (tx_q)
  );

  // Receive buffer: bus writes, host reads.
  i2cse_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (item.bus_byte),
    .re    (accept),
    .raddr (idx_addr),
    .rdata (rx_q)
  );

  // Written-entry flags; an unwritten entry reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_vld_r <= '0;
      rx_vld_r <= '0;
    end else begin
      if (tx_we) begin
        tx_vld_r[idx_addr] <= 1'b1;
      end
      if (rx_we) begin
        rx_vld_r[rx_waddr] <= 1'b1;
      end
    end
  end

  // Stage one: event result, waiting for the buffer read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r   <= ev_res;
      s1_tx_ok_r <= ev_res.send_valid && tx_vld_r[tx_raddr];
      s1_rx_ok_r <= (item.kind == i2cse_pkg::KIND_READ) && in_range && rx_vld_r[idx_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.event_class    <= s1_res_r.event_class;
      out_data_r.send_valid     <= s1_res_r.send_valid;
      out_data_r.send_byte      <= s1_tx_ok_r ? tx_q : 8'd0;
      out_data_r.message_ready  <= s1_res_r.message_ready;
      out_data_r.message_length <= s1_res_r.message_length;
      out_data_r.protocol_error <= s1_res_r.protocol_error;
      out_data_r.read_data      <= s1_rx_ok_r ? rx_q : 8'd0;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

  // A completed message only comes with stop or an address event.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r && out_data_r.message_ready |->
                   (out_data_r.event_class == i2cse_pkg::EV_STOP) ||
                   (out_data_r.event_class == i2cse_pkg::EV_ADDR_W) ||
                   (out_data_r.event_class == i2cse_pkg::EV_ADDR_R))
    else $error("message reported on a wrong event class");

  // A byte is sent exactly on read events.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r |->
                   out_data_r.send_valid ==
                   ((out_data_r.event_class == i2cse_pkg::EV_ADDR_R) ||
                    (out_data_r.event_class == i2cse_pkg::EV_DATA_R)))
    else $error("send flag does not match event class");

  // A stalled stage-one result is neither lost nor overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
                   s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_res_r))
    else $error("stage one result changed while stalled");

endmodule

@@ verif/i2c_slave_event_handler_core_tb.sv @@
// ----------------------------------------------------------------------------
// i2c_slave_event_handler_core_tb
// Drives the slave event handler with bus status events and host buffer
// requests through its valid/ready channels. It predicts every result with a
// behavioral copy of the receive and transmit buffers and compares each
// result field by field. The slave address register is written and read back
// between phases. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module i2c_slave_event_handler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DEPTH           = 32;
  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         DRAIN_CYCLES    = 8;
  localparam logic [1:0] KIND_UNUSED     = 2'd3;
  localparam logic [2:0] REG_OWN_ADDRESS = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2cse_chan_if #(.T(i2cse_pkg::in_t))  in_chan ();
  i2cse_chan_if #(.T(i2cse_pkg::out_t)) out_chan ();

  i2c_slave_event_handler_core #(.BUFFER_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Requests waiting to be driven and responses waiting to arrive.
  i2cse_pkg::in_t  request_backlog[$];
  i2cse_pkg::out_t awaited_responses[$];
  int              requests_queued;
  int              fail_count;
  int              cycle_count;

  // Shadow of the slave port: buffers, counters and the sticky error.
  logic [7:0] rx_store [DEPTH];
  logic [7:0] tx_store [DEPTH];
  int         rx_count;
  int         tx_ptr;
  bit         rx_pending;
  bit         error_sticky;
  logic [6:0] own_address_shadow;

  // Idle control for both channel sides.
  int req_gap;
  int rsp_stall;
  bit req_burst;
  bit rsp_burst;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Decode a status byte into an event class, highest priority first.
  function automatic logic [3:0] decode_status(logic [7:0] status, logic released);
    logic [7:0] ev_bits;
    ev_bits = status & i2cse_pkg::MASK_EV;
    if ((status & i2cse_pkg::MASK_LOW) == i2cse_pkg::PAT_START) return i2cse_pkg::EV_START;
    if ((status & i2cse_pkg::MASK_STOP) == i2cse_pkg::MASK_STOP) return i2cse_pkg::EV_STOP;
    if (ev_bits == i2cse_pkg::PAT_ADDR_W) return i2cse_pkg::EV_ADDR_W;
    if ((ev_bits | i2cse_pkg::PAT_START) == i2cse_pkg::PAT_DATA_W) return i2cse_pkg::EV_DATA_W;
    if ((ev_bits & i2cse_pkg::MASK_ADDR_R) == i2cse_pkg::PAT_ADDR_R) return i2cse_pkg::EV_ADDR_R;
    if ((ev_bits & i2cse_pkg::MASK_DATA_R) == i2cse_pkg::PAT_DATA_R) begin
      return released ? i2cse_pkg::EV_NACK : i2cse_pkg::EV_DATA_R;
    end
    return i2cse_pkg::EV_ERROR;
  endfunction

  // Hand a pending received message to the host, if there is one.
  function automatic void close_message(inout i2cse_pkg::out_t rsp);
    if (rx_pending) begin
      rsp.message_ready  = 1'b1;
      rsp.message_length = 6'(rx_count);
      rx_count           = 0;
      rx_pending         = 1'b0;
    end
  endfunction

  // Expected response to one accepted request; updates the shadow state.
  function automatic i2cse_pkg::out_t model_slave_event(i2cse_pkg::in_t req);
    i2cse_pkg::out_t rsp;
    logic [3:0]      cls;
    rsp = '0;
    case (req.kind)
      i2cse_pkg::KIND_BUS: begin
        cls = error_sticky ? i2cse_pkg::EV_ERROR
                           : decode_status(req.status_bits, req.clock_released);
        rsp.event_class = cls;
        if (!error_sticky) begin
          case (cls)
            i2cse_pkg::EV_STOP, i2cse_pkg::EV_ADDR_W: begin
              close_message(rsp);
            end
            i2cse_pkg::EV_DATA_W: begin
              rx_pending = 1'b1;
              if (rx_count < DEPTH) begin
                rx_store[rx_count] = req.bus_byte;
                rx_count++;
              end
            end
            i2cse_pkg::EV_ADDR_R: begin
              close_message(rsp);
              rsp.send_valid = 1'b1;
              rsp.send_byte  = tx_store[0];
              tx_ptr         = 1;
            end
            i2cse_pkg::EV_DATA_R: begin
              // The pointer parks on the last entry, which then repeats.
              rsp.send_valid = 1'b1;
              rsp.send_byte  = tx_store[tx_ptr];
              if (tx_ptr < DEPTH - 1) tx_ptr++;
            end
            i2cse_pkg::EV_ERROR: begin
              error_sticky = 1'b1;
            end
            default: ;
          endcase
        end
      end
      i2cse_pkg::KIND_LOAD: begin
        tx_store[req.table_index] = req.table_data;
      end
      i2cse_pkg::KIND_READ: begin
        rsp.read_data = rx_store[req.table_index];
      end
      default: ;
    endcase
    rsp.protocol_error = error_sticky;
    return rsp;
  endfunction

  // Draw a status byte that decodes to the wanted class.
  function automatic logic [7:0] pick_status(logic [3:0] cls);
    logic [7:0] status;
    logic [3:0] want;
    want = (cls == i2cse_pkg::EV_NACK) ? i2cse_pkg::EV_DATA_R : cls;
    do status = 8'($urandom_range(0, 255));
    while (decode_status(status, 1'b0) != want);
    return status;
  endfunction

  function automatic i2cse_pkg::in_t random_request();
    i2cse_pkg::in_t req;
    req.kind           = 2'($urandom_range(0, 3));
    req.status_bits    = 8'($urandom_range(0, 255));
    req.overflow       = 1'($urandom_range(0, 1));
    req.clock_released = 1'($urandom_range(0, 1));
    req.bus_byte       = 8'($urandom_range(0, 255));
    req.table_index    = 5'($urandom_range(0, DEPTH - 1));
    req.table_data     = 8'($urandom_range(0, 255));
    return req;
  endfunction

  function automatic i2cse_pkg::in_t bus_request(logic [3:0] cls);
    i2cse_pkg::in_t req;
    req                = random_request();
    req.kind           = i2cse_pkg::KIND_BUS;
    req.status_bits    = pick_status(cls);
    req.clock_released = (cls == i2cse_pkg::EV_NACK);
    return req;
  endfunction

  function automatic i2cse_pkg::in_t host_request(logic [1:0] kind, int idx, int data);
    i2cse_pkg::in_t req;
    req             = random_request();
    req.kind        = kind;
    req.table_index = 5'(idx);
    req.table_data  = 8'(data);
    return req;
  endfunction

  // Gaps come in stretches: now and then the side switches between idling
  // at random and running flat out.
  function automatic int draw_pause(inout bit burst);
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic queue_request(i2cse_pkg::in_t req);
    request_backlog.push_back(req);
    if (req.kind != KIND_UNUSED) requests_queued++;
  endtask

  // Wait until every request is out and every response is back. The check
  // runs at the falling edge, once the rising-edge updates have settled.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_chan.valid || awaited_responses.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the slave address register, then read it back.
  task automatic program_own_address(logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_OWN_ADDRESS;
    pwdata  <= {25'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    own_address_shadow = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {25'b0, own_address_shadow}) begin
      $error("own_address mismatch: expected %0d, actual %0d", own_address_shadow, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed write and read transfers with random content, plus
  // host buffer traffic and stray events.
  task automatic queue_random_traffic(int target);
    int stop_at;
    int sel;
    int len;
    stop_at = requests_queued + target;
    while (requests_queued < stop_at) begin
      sel = $urandom_range(0, 9);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
      if (sel < 4) begin
        queue_request(bus_request(i2cse_pkg::EV_START));
        queue_request(bus_request(i2cse_pkg::EV_ADDR_W));
        repeat (len) queue_request(bus_request(i2cse_pkg::EV_DATA_W));
        case ($urandom_range(0, 5))
          4:       queue_request(bus_request(i2cse_pkg::EV_ADDR_W));
          5:       queue_request(bus_request(i2cse_pkg::EV_ADDR_R));
          default: queue_request(bus_request(i2cse_pkg::EV_STOP));
        endcase
      end else if (sel < 7) begin
        queue_request(bus_request(i2cse_pkg::EV_START));
        queue_request(bus_request(i2cse_pkg::EV_ADDR_R));
        repeat (len) queue_request(bus_request(i2cse_pkg::EV_DATA_R));
        if ($urandom_range(0, 4) != 0) queue_request(bus_request(i2cse_pkg::EV_NACK));
        if ($urandom_range(0, 9) != 0) queue_request(bus_request(i2cse_pkg::EV_STOP));
      end else if (sel < 9) begin
        repeat ($urandom_range(1, 6)) begin
          queue_request(host_request($urandom_range(0, 1) ? i2cse_pkg::KIND_LOAD
                                                          : i2cse_pkg::KIND_READ,
                                     $urandom_range(0, DEPTH - 1), $urandom_range(0, 255)));
        end
      end else if ($urandom_range(0, 4) == 0) begin
        queue_request(host_request(KIND_UNUSED, $urandom_range(0, DEPTH - 1),
                                   $urandom_range(0, 255)));
      end else begin
        queue_request(bus_request(4'($urandom_range(i2cse_pkg::EV_START, i2cse_pkg::EV_NACK))));
      end
    end
  endtask

  // Request driver: presents the backlog with a random gap between requests.
  always @(posedge clk) begin : request_driver
    logic next_valid;
    next_valid = in_chan.valid;
    if (!rst_n) begin
      next_valid = 1'b0;
      req_gap    = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        awaited_responses.push_back(model_slave_event(in_chan.payload));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (request_backlog.size() != 0) begin
          in_chan.payload <= request_backlog.pop_front();
          next_valid = 1'b1;
          req_gap    = draw_pause(req_burst);
        end
      end
    end
    in_chan.valid <= next_valid;
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Response monitor: stalls at random and checks each response in order.
  always @(posedge clk) begin : response_monitor
    i2cse_pkg::out_t want;
    i2cse_pkg::out_t got;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.payload;
        if (awaited_responses.size() == 0) begin
          $error("unexpected response: event_class %0d", got.event_class);
          fail_count++;
        end else begin
          want = awaited_responses.pop_front();
          check_field("event_class", want.event_class, got.event_class);
          check_field("send_valid", want.send_valid, got.send_valid);
          check_field("send_byte", want.send_byte, got.send_byte);
          check_field("message_ready", want.message_ready, got.message_ready);
          check_field("message_length", want.message_length, got.message_length);
          check_field("protocol_error", want.protocol_error, got.protocol_error);
          check_field("read_data", want.read_data, got.read_data);
        end
        rsp_stall = draw_pause(rsp_burst);
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    i2cse_pkg::in_t req;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_chan.valid   = 1'b0;
    in_chan.payload = '0;
    out_chan.ready  = 1'b0;
    requests_queued = 0;
    fail_count      = 0;
    cycle_count     = 0;
    req_burst       = 1'b0;
    rsp_burst       = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      rx_store[i] = '0;
      tx_store[i] = '0;
    end
    rx_count           = 0;
    tx_ptr             = 0;
    rx_pending         = 1'b0;
    error_sticky       = 1'b0;
    own_address_shadow = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    program_own_address(7'h7F);

    // Buffers read as zero after reset; load the transmit ends and entry 1.
    queue_request(host_request(i2cse_pkg::KIND_READ, 0, 0));
    queue_request(host_request(i2cse_pkg::KIND_READ, DEPTH - 1, 0));
    queue_request(host_request(i2cse_pkg::KIND_LOAD, 0, 8'hFF));
    queue_request(host_request(i2cse_pkg::KIND_LOAD, DEPTH - 1, 8'h00));
    queue_request(host_request(i2cse_pkg::KIND_LOAD, 1, 8'h5A));
    // Write transfer of two bytes, one with the overflow flag, then a stop
    // with every status bit set, and a second stop with nothing pending.
    queue_request(bus_request(i2cse_pkg::EV_START));
    queue_request(bus_request(i2cse_pkg::EV_ADDR_W));
    req          = bus_request(i2cse_pkg::EV_DATA_W);
    req.bus_byte = 8'h00;
    req.overflow = 1'b1;
    queue_request(req);
    req          = bus_request(i2cse_pkg::EV_DATA_W);
    req.bus_byte = 8'hFF;
    req.overflow = 1'b0;
    queue_request(req);
    req             = bus_request(i2cse_pkg::EV_STOP);
    req.status_bits = 8'hFF;
    queue_request(req);
    queue_request(bus_request(i2cse_pkg::EV_STOP));
    queue_request(bus_request(i2cse_pkg::EV_ADDR_W));
    // Read transfer ended by the master's nack.
    queue_request(bus_request(i2cse_pkg::EV_START));
    queue_request(bus_request(i2cse_pkg::EV_ADDR_R));
    queue_request(bus_request(i2cse_pkg::EV_DATA_R));
    queue_request(bus_request(i2cse_pkg::EV_NACK));
    queue_request(bus_request(i2cse_pkg::EV_STOP));
    queue_request(host_request(i2cse_pkg::KIND_READ, 0, 0));
    queue_request(host_request(i2cse_pkg::KIND_READ, 1, 0));
    queue_request(host_request(KIND_UNUSED, 3, 8'h33));
    // A repeated start closes the pending message, for read and for write.
    queue_request(bus_request(i2cse_pkg::EV_DATA_W));
    queue_request(bus_request(i2cse_pkg::EV_ADDR_R));
    queue_request(bus_request(i2cse_pkg::EV_DATA_W));
    queue_request(bus_request(i2cse_pkg::EV_ADDR_W));
    wait_for_drain();

    program_own_address(7'h00);
    queue_random_traffic(300);
    wait_for_drain();
    program_own_address(7'($urandom_range(0, 127)));
    queue_random_traffic(300);
    wait_for_drain();
    program_own_address(7'h7F);
    queue_random_traffic(300);
    wait_for_drain();
    program_own_address(7'($urandom_range(0, 127)));

    // An unknown status pattern latches the error; later bus events report
    // the error class while host requests still work.
    queue_request(bus_request(i2cse_pkg::EV_DATA_W));
    req             = bus_request(i2cse_pkg::EV_ERROR);
    req.status_bits = 8'h00;
    queue_request(req);
    repeat (12) begin
      queue_request(bus_request(4'($urandom_range(i2cse_pkg::EV_START, i2cse_pkg::EV_NACK))));
    end
    repeat (6) begin
      queue_request(host_request($urandom_range(0, 1) ? i2cse_pkg::KIND_LOAD
                                                      : i2cse_pkg::KIND_READ,
                                 $urandom_range(0, DEPTH - 1), $urandom_range(0, 255)));
    end
    repeat (4) queue_request(bus_request(i2cse_pkg::EV_ERROR));
    queue_request(bus_request(i2cse_pkg::EV_STOP));
    wait_for_drain();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
